// ===== hdl/wgbb_pkg.sv =====
// ----------------------------------------------------------------------------
// wgbb_pkg
// Shared types, constants and helpers of the windowed Goertzel bin bank.
// ----------------------------------------------------------------------------
package wgbb_pkg;

   localparam int NUM_BINS_DEF  = 64;
   localparam int FRAME_LEN_DEF = 256;

   localparam int ACC_W   = 100;  // multiply-accumulate width
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RAD_W   = 98;   // radicand of the magnitude square root
   localparam int ROOT_W  = 49;

   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_WINDOW  = 2'd1;
   localparam logic [1:0] CMD_TWIDDLE = 2'd2;

   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_24 = 2'd1;
   localparam logic [1:0] SH_48 = 2'd2;

   localparam logic [31:0] GAIN_RST = 32'd16777216;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         index;
      logic signed [23:0] sample;
      logic [14:0]        window_weight;
      logic signed [31:0] cos_value;
      logic signed [31:0] sin_value;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  bin;
      logic [15:0] magnitude;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic                      valid;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
      logic [1:0]                shift;
   } mul_req_type;

   function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
      logic signed [51:0] hi;
      logic signed [51:0] lo;
      hi = 52'sh0_7FFF_FFFF_FFFF;
      lo = -hi - 52'sd1;
      if (v > hi) return 48'sh7FFF_FFFF_FFFF;
      if (v < lo) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   function automatic logic [47:0] abs48(input logic signed [47:0] v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

endpackage

// ===== hdl/wgbb_mac.sv =====
// ----------------------------------------------------------------------------
// wgbb_mac
// Shared signed multiplier with a registered product and a shifting
// accumulator; the registered product is added into the accumulator register.
// ----------------------------------------------------------------------------
module wgbb_mac
   import wgbb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mul_req_type             mul_req,
   input  logic                    clear,
   input  logic signed [ACC_W-1:0] init,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic [1:0]               shift_ff;
   logic                     pvalid_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      case (shift_ff)
         SH_0:    addend = prod_ext;
         SH_24:   addend = prod_ext <<< 24;
         SH_48:   addend = prod_ext <<< 48;
         default: addend = '0;
      endcase
      acc_in = (clear ? init : acc_ff) + (pvalid_ff ? addend : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= mul_req.valid;
      end
      prod_ff  <= mul_req.a * mul_req.b;
      shift_ff <= mul_req.shift;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== hdl/wgbb_sqrt.sv =====
// ----------------------------------------------------------------------------
// wgbb_sqrt
// Integer square root, one result bit per cycle (restoring, two radicand
// bits shifted in per step).
// ----------------------------------------------------------------------------
module wgbb_sqrt
   import wgbb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff, rem_in, rem2, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff, done_ff;

   always_comb begin
      rem2  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      if (rem2 >= trial) begin
         rem_in  = rem2 - trial;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem2;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(ROOT_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// ===== hdl/windowed_goertzel_bin_bank_core.sv =====
// ----------------------------------------------------------------------------
// windowed_goertzel_bin_bank_core
// Windowed Goertzel filter bank: window, twiddle and recurrence state live in
// single-port synchronous memories; one shared multiplier serves all multiplications.
// ----------------------------------------------------------------------------
// Load words (window weight, cos/sin pair) are taken while idle; busy stays low.
// A sample word is windowed (ST_WML, ST_WW1, ST_WX), then each bin runs one state
// read, two partial products on the shared multiplier, one accumulate and one write.
// The frame-closing sample then runs per bin the re and im products, the sum of
// squares, the square root and the gain scaling; each magnitude shows on rsp_*
// for one cycle, rsp_valid high, and the receiver cannot stall it.
// Reset (synchronous) zeroes the recurrence state via per-bin valid bits and
// restores gain_ff to 2^24 (1/128); window and twiddle memories are not cleared.
// ----------------------------------------------------------------------------
module windowed_goertzel_bin_bank_core
   import wgbb_pkg::*;
#(
   parameter int NUM_BINS  = NUM_BINS_DEF,
   parameter int FRAME_LEN = FRAME_LEN_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int WIN_AW = $clog2(FRAME_LEN);

   localparam logic signed [ACC_W-1:0] RND_WIN  = ACC_W'(1) <<< 14;
   localparam logic signed [ACC_W-1:0] RND_29   = ACC_W'(1) <<< 28;
   localparam logic signed [ACC_W-1:0] RND_30   = ACC_W'(1) <<< 29;
   localparam logic signed [ACC_W-1:0] RND_GAIN = ACC_W'(1) <<< 30;
   localparam logic signed [ACC_W-1:0] GAIN_SAT = (ACC_W'(1) <<< 48) + RND_GAIN;

   typedef enum logic [24:0] {
      ST_IDLE = 25'd1 << 0,  ST_WML = 25'd1 << 1,  ST_WW1 = 25'd1 << 2,
      ST_WX   = 25'd1 << 3,  ST_BRD = 25'd1 << 4,  ST_BML = 25'd1 << 5,
      ST_BMH  = 25'd1 << 6,  ST_BW1 = 25'd1 << 7,  ST_BWB = 25'd1 << 8,
      ST_FRD  = 25'd1 << 9,  ST_FC1 = 25'd1 << 10, ST_FC2 = 25'd1 << 11,
      ST_FC3  = 25'd1 << 12, ST_FRE = 25'd1 << 13, ST_FS2 = 25'd1 << 14,
      ST_FS3  = 25'd1 << 15, ST_FIM = 25'd1 << 16, ST_FSQ = 25'd1 << 17,
      ST_FSQW = 25'd1 << 18, ST_FSR = 25'd1 << 19, ST_FSW = 25'd1 << 20,
      ST_FGL  = 25'd1 << 21, ST_FGH = 25'd1 << 22, ST_FG3 = 25'd1 << 23,
      ST_FOUT = 25'd1 << 24
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [WIN_AW-1:0] count_ff, count_in;
   logic [2:0]        sq_ff, sq_in;
   logic [31:0]       gain_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_BINS-1:0] vld_ff;

   // payload registers
   logic signed [23:0] smp_ff;
   logic signed [24:0] x_ff, x_in;
   logic [47:0]        are_ff, are_in, aim_ff, aim_in;
   rsp_word_type       rsp_ff, rsp_in;

   // memories and their read registers
   logic [14:0] win_mem [FRAME_LEN];
   logic [95:0] st_mem  [NUM_BINS];
   logic [63:0] cf_mem  [NUM_BINS];
   logic [14:0] win_rd_ff;
   logic [95:0] st_rd_ff;
   logic [63:0] cf_rd_ff;
   logic        vld_rd_ff;

   logic        accept, last_bin;
   logic        win_we, win_rd, cf_we, st_rd, st_wr, vld_clr;
   logic [95:0] st_wdata;

   mul_req_type             mreq;
   logic                    mac_clr;
   logic signed [ACC_W-1:0] mac_init, acc;
   logic                    sq_start, sq_done;
   logic [ROOT_W-1:0]       root;

   logic signed [47:0] s1, s2, re_v, im_v, s0_v;
   logic signed [31:0] cos_v, sin_v;
   logic signed [51:0] t_v;
   logic [17:0]        qw;
   logic [23:0]        sq_lo, sq_hi;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign last_bin = (bin_ff == BIN_W'(NUM_BINS - 1));

   // a bin not written since reset or the last frame reads as zero
   assign s1    = vld_rd_ff ? st_rd_ff[95:48] : '0;
   assign s2    = vld_rd_ff ? st_rd_ff[47:0]  : '0;
   assign cos_v = cf_rd_ff[63:32];
   assign sin_v = cf_rd_ff[31:0];

   wgbb_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mreq),
      .clear   (mac_clr),
      .init    (mac_init),
      .acc     (acc)
   );

   wgbb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc[RAD_W-1:0]),
      .root     (root),
      .done     (sq_done)
   );

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      count_in     = count_ff;
      sq_in        = sq_ff;
      x_in         = x_ff;
      are_in       = are_ff;
      aim_in       = aim_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mreq         = '0;
      mac_clr      = 1'b0;
      mac_init     = '0;
      sq_start     = 1'b0;
      win_we       = 1'b0;
      win_rd       = 1'b0;
      cf_we        = 1'b0;
      st_rd        = 1'b0;
      st_wr        = 1'b0;
      vld_clr      = 1'b0;
      t_v          = acc[80:29];
      s0_v         = sat48(52'(x_ff) + t_v - 52'(s2));
      re_v         = sat48(52'(s1) - acc[81:30]);
      im_v         = sat48(acc[81:30]);
      st_wdata     = {s0_v, s1};
      qw           = acc[48:31];
      sq_lo        = (sq_ff < 3'd3) ? are_ff[23:0]  : aim_ff[23:0];
      sq_hi        = (sq_ff < 3'd3) ? are_ff[47:24] : aim_ff[47:24];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_SAMPLE: begin
                     win_rd   = 1'b1;
                     state_in = ST_WML;
                  end
                  CMD_WINDOW: begin
                     win_we = ({1'b0, req_data.index} < 11'(FRAME_LEN));
                  end
                  CMD_TWIDDLE: begin
                     cf_we = ({1'b0, req_data.index} < 11'(NUM_BINS));
                  end
                  default: begin
                  end
               endcase
            end
         end
         // window the sample: x = round(sample * weight / 2^15)
         ST_WML: begin
            mreq     = '{1'b1, MUL_A_W'(smp_ff), MUL_B_W'({1'b0, win_rd_ff}), SH_0};
            mac_clr  = 1'b1;
            mac_init = RND_WIN;
            state_in = ST_WW1;
         end
         ST_WW1: state_in = ST_WX;
         ST_WX: begin
            x_in     = acc[39:15];
            bin_in   = '0;
            state_in = ST_BRD;
         end
         // recurrence per bin: s0 = x + round(s1*cos/2^29) - s2
         ST_BRD: begin
            st_rd    = 1'b1;
            state_in = ST_BML;
         end
         ST_BML: begin
            mreq     = '{1'b1, MUL_A_W'({1'b0, s1[23:0]}), MUL_B_W'(cos_v), SH_0};
            mac_clr  = 1'b1;
            mac_init = RND_29;
            state_in = ST_BMH;
         end
         ST_BMH: begin
            mreq     = '{1'b1, MUL_A_W'($signed(s1[47:24])), MUL_B_W'(cos_v), SH_24};
            state_in = ST_BW1;
         end
         ST_BW1: state_in = ST_BWB;
         ST_BWB: begin
            st_wr = 1'b1;
            if (!last_bin) begin
               bin_in   = bin_ff + BIN_W'(1);
               state_in = ST_BRD;
            end else if (count_ff == WIN_AW'(FRAME_LEN - 1)) begin
               bin_in   = '0;
               state_in = ST_FRD;
            end else begin
               count_in = count_ff + WIN_AW'(1);
               state_in = ST_IDLE;
            end
         end
         // frame end: re = s1 - round(s2*cos/2^30)
         ST_FRD: begin
            st_rd    = 1'b1;
            state_in = ST_FC1;
         end
         ST_FC1: begin
            mreq     = '{1'b1, MUL_A_W'({1'b0, s2[23:0]}), MUL_B_W'(cos_v), SH_0};
            mac_clr  = 1'b1;
            mac_init = RND_30;
            state_in = ST_FC2;
         end
         ST_FC2: begin
            mreq     = '{1'b1, MUL_A_W'($signed(s2[47:24])), MUL_B_W'(cos_v), SH_24};
            state_in = ST_FC3;
         end
         ST_FC3: state_in = ST_FRE;
         // latch |re|, start im = round(s2*sin/2^30)
         ST_FRE: begin
            are_in   = abs48(re_v);
            mreq     = '{1'b1, MUL_A_W'({1'b0, s2[23:0]}), MUL_B_W'(sin_v), SH_0};
            mac_clr  = 1'b1;
            mac_init = RND_30;
            state_in = ST_FS2;
         end
         ST_FS2: begin
            mreq     = '{1'b1, MUL_A_W'($signed(s2[47:24])), MUL_B_W'(sin_v), SH_24};
            state_in = ST_FS3;
         end
         ST_FS3: state_in = ST_FIM;
         ST_FIM: begin
            aim_in   = abs48(im_v);
            sq_in    = '0;
            state_in = ST_FSQ;
         end
         // re^2 + im^2 from lo*lo, 2*hi*lo and hi*hi of each
         ST_FSQ: begin
            mac_clr = (sq_ff == 3'd0);
            case (sq_ff)
               3'd0, 3'd3: mreq = '{1'b1, MUL_A_W'({1'b0, sq_lo}),
                                    MUL_B_W'({1'b0, sq_lo}), SH_0};
               3'd1, 3'd4: mreq = '{1'b1, MUL_A_W'({1'b0, sq_hi}),
                                    MUL_B_W'({1'b0, sq_lo, 1'b0}), SH_24};
               default:    mreq = '{1'b1, MUL_A_W'({1'b0, sq_hi}),
                                    MUL_B_W'({1'b0, sq_hi}), SH_48};
            endcase
            if (sq_ff == 3'd5) begin
               state_in = ST_FSQW;
            end else begin
               sq_in = sq_ff + 3'd1;
            end
         end
         ST_FSQW: state_in = ST_FSR;
         ST_FSR: begin
            sq_start = 1'b1;
            state_in = ST_FSW;
         end
         ST_FSW: begin
            if (sq_done) begin
               state_in = ST_FGL;
            end
         end
         // scale by the gain: round(m * gain / 2^31), saturate
         ST_FGL: begin
            mreq     = '{1'b1, MUL_A_W'({1'b0, root[23:0]}),
                         MUL_B_W'({1'b0, gain_ff}), SH_0};
            mac_clr  = 1'b1;
            mac_init = RND_GAIN;
            state_in = ST_FGH;
         end
         ST_FGH: begin
            mreq     = '{1'b1, MUL_A_W'({1'b0, root[ROOT_W-1:24]}),
                         MUL_B_W'({1'b0, gain_ff}), SH_24};
            state_in = ST_FG3;
         end
         ST_FG3: state_in = ST_FOUT;
         ST_FOUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.bin   = 6'(bin_ff);
            rsp_in.last  = last_bin;
            if (acc > GAIN_SAT || qw > 18'd65535) begin
               rsp_in.magnitude = 16'hFFFF;
            end else begin
               rsp_in.magnitude = qw[15:0];
            end
            if (last_bin) begin
               vld_clr  = 1'b1;
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               bin_in   = bin_ff + BIN_W'(1);
               state_in = ST_FRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bin_ff       <= '0;
         count_ff     <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         gain_ff      <= GAIN_RST;
      end else begin
         state_ff     <= state_in;
         bin_ff       <= bin_in;
         count_ff     <= count_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (vld_clr) begin
            vld_ff <= '0;
         end else if (st_wr) begin
            vld_ff[bin_ff] <= 1'b1;
         end
         if (psel && penable && pwrite && !paddr[2]) begin
            gain_ff <= pwdata;
         end
      end
      if (accept) begin
         smp_ff <= req_data.sample;
      end
      x_ff   <= x_in;
      are_ff <= are_in;
      aim_ff <= aim_in;
      rsp_ff <= rsp_in;
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[req_data.index[WIN_AW-1:0]] <= req_data.window_weight;
      end
      if (win_rd) begin
         win_rd_ff <= win_mem[count_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cf_we) begin
         cf_mem[req_data.index[BIN_W-1:0]] <= {req_data.cos_value, req_data.sin_value};
      end
      if (st_rd) begin
         cf_rd_ff <= cf_mem[bin_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (st_wr) begin
         st_mem[bin_ff] <= st_wdata;
      end
      if (st_rd) begin
         st_rd_ff  <= st_mem[bin_ff];
         vld_rd_ff <= vld_ff[bin_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prdata    = paddr[2] ? 32'd0 : gain_ff;
   assign pready    = 1'b1;

   // results are spaced by the per-bin sequence: never two in a row
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // a sample word always starts the per-bin sequence
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_SAMPLE) |=> busy)
      else $error("sample word did not start work");

   // the last bin of a frame rewinds the frame position
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (count_ff == '0 && !busy))
      else $error("frame position not rewound");

endmodule
